/* rtl/nwt_pkg.sv */
// ----------------------------------------------------------------------------
// nwt_pkg
// Types, word codes and slot decoding shared by the number-to-words block.
// ----------------------------------------------------------------------------
package nwt_pkg;

  localparam logic [5:0] W_ZERO       = 6'd0;
  localparam logic [5:0] W_ERROR      = 6'd1;
  localparam logic [5:0] W_MINUS      = 6'd2;
  localparam logic [5:0] W_POINT      = 6'd3;
  localparam logic [5:0] W_THOUSAND   = 6'd4;
  localparam logic [5:0] W_THOUSANDS  = 6'd5;
  localparam logic [5:0] W_HUNDRED    = 6'd6;
  localparam logic [5:0] W_TWOHUNDRED = 6'd7;
  localparam logic [5:0] W_HUND_FEW   = 6'd8;
  localparam logic [5:0] W_HUND_MANY  = 6'd9;
  localparam logic [5:0] W_TENS_BASE  = 6'd8;
  localparam logic [5:0] W_UNIT_BASE  = 6'd17;

  localparam logic [4:0] SLOT_MINUS  = 5'd0;
  localparam logic [4:0] SLOT_ERROR  = 5'd1;
  localparam logic [4:0] SLOT_ZERO   = 5'd2;
  localparam logic [4:0] SLOT_INT    = 5'd3;
  localparam logic [4:0] SLOT_POINT  = 5'd12;
  localparam logic [4:0] SLOT_LZ1    = 5'd13;
  localparam logic [4:0] SLOT_LZ2    = 5'd14;
  localparam logic [4:0] SLOT_FRAC   = 5'd15;
  localparam logic [4:0] SLOT_LAST   = 5'd23;

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SPEAK, ST_FLUSH} state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic speak;
    logic flush;
  } nwt_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic slot_end;
  } nwt_stat_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] word;
  } slot_t;

  function automatic slot_t below_slot(input logic [3:0] h, input logic [3:0] t,
                                       input logic [3:0] u, input logic [1:0] j);
    slot_t s;
    s = '0;
    unique case (j)
      2'd0: begin
        if (h >= 4'd3) begin
          s.valid = 1'b1;
          s.word  = W_UNIT_BASE + {2'b00, h};
        end
      end
      2'd1: begin
        if (h != 4'd0) begin
          s.valid = 1'b1;
          if (h == 4'd1) s.word = W_HUNDRED;
          else if (h == 4'd2) s.word = W_TWOHUNDRED;
          else if (h <= 4'd4) s.word = W_HUND_FEW;
          else s.word = W_HUND_MANY;
        end
      end
      2'd2: begin
        if (t >= 4'd2) begin
          s.valid = 1'b1;
          s.word  = W_TENS_BASE + {2'b00, t};
        end
      end
      default: begin
        if (t == 4'd1) begin
          s.valid = 1'b1;
          s.word  = W_UNIT_BASE + 6'd10 + {2'b00, u};
        end else if (u != 4'd0) begin
          s.valid = 1'b1;
          s.word  = W_UNIT_BASE + {2'b00, u};
        end
      end
    endcase
    return s;
  endfunction

  function automatic slot_t mag_slot(input logic [23:0] dg, input logic [3:0] k);
    slot_t s;
    logic  exact;
    logic  [3:0] kr;
    s     = '0;
    exact = (dg[23:12] == 12'h001) && (dg[11:0] == 12'h000);
    kr    = k - 4'd5;
    if (k < 4'd4) begin
      if (!exact) s = below_slot(dg[23:20], dg[19:16], dg[15:12], k[1:0]);
    end else if (k == 4'd4) begin
      if (dg[23:12] != 12'h000) begin
        s.valid = 1'b1;
        if (!exact && dg[15:12] >= 4'd2 && dg[15:12] <= 4'd4) s.word = W_THOUSANDS;
        else s.word = W_THOUSAND;
      end
    end else if (k <= 4'd8) begin
      s = below_slot(dg[11:8], dg[7:4], dg[3:0], kr[1:0]);
    end
    return s;
  endfunction

endpackage

/* rtl/number_to_word_tokens_top.sv */
// ----------------------------------------------------------------------------
// number_to_word_tokens_top
// Turns a signed integer or fixed-point number into Czech word codes.
//
//   Channel   Signals                     Transfer
//   command   start, busy, cmd, value,    start high while busy low
//             decimals
//   result    strobe, word, last          one cycle per word, strobe high
//
// An item passes through a load, the shift-and-add decimal conversion, a
// walk of the fixed list of word slots and a flush of the final word.
// Words appear one per strobe, last on the final one.
// Reset returns the controller to idle and drops any pending word.
// The receiver cannot stall; busy holds off new commands.
// ----------------------------------------------------------------------------
module number_to_word_tokens_top
  import nwt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic signed [31:0] value,
  input  logic [2:0]         decimals,
  output logic               strobe,
  output logic [5:0]         word,
  output logic               last
);

  nwt_cmd_t  ctl;
  nwt_stat_t stat;

  nwt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  nwt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .stat     (stat),
    .cmd      (cmd),
    .value    (value),
    .decimals (decimals),
    .strobe   (strobe),
    .word     (word),
    .last     (last)
  );

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised after a transaction");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe) else $error("word straight after the final word");

  a_word_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (word <= 6'd36)) else $error("word code out of range");

  a_no_word_at_load: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !strobe) else $error("word during conversion");

endmodule

/* rtl/nwt_ctrl.sv */
// ----------------------------------------------------------------------------
// nwt_ctrl
// Sequencer: binary to decimal conversion, word slot walk and final flush.
// ----------------------------------------------------------------------------
module nwt_ctrl
  import nwt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  nwt_stat_t stat,
  output nwt_cmd_t  ctl,
  output logic      busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_CONV;
      ST_CONV:  if (stat.conv_done) state_next = ST_SPEAK;
      ST_SPEAK: if (stat.slot_end) state_next = ST_FLUSH;
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:  ctl.load  = start;
      ST_CONV:  ctl.shift = 1'b1;
      ST_SPEAK: ctl.speak = 1'b1;
      ST_FLUSH: ctl.flush = 1'b1;
      default:  ctl = '0;
    endcase
  end

endmodule

/* rtl/nwt_dp.sv */
// ----------------------------------------------------------------------------
// nwt_dp
// Datapath: magnitude to BCD by shift-and-add, word slot decoding and a
// one-word look-ahead register that marks the final word.
// ----------------------------------------------------------------------------
module nwt_dp
  import nwt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  nwt_cmd_t           ctl,
  output nwt_stat_t          stat,
  input  logic               cmd,
  input  logic signed [31:0] value,
  input  logic [2:0]         decimals,
  output logic               strobe,
  output logic [5:0]         word,
  output logic               last
);

  logic        cmd_r, neg;
  logic [2:0]  dec;
  logic [31:0] bin;
  logic [39:0] bcd, bcd_adj, bs;
  logic [4:0]  cnt, slot;
  logic        pvalid;
  logic [5:0]  pword;
  logic        bad, interr, intzero, frzero;
  logic [1:0]  sh, top, lz;
  logic [11:0] fr, fv;
  logic [23:0] nd;
  logic [4:0]  ki, kf;
  slot_t       cur;

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_comb begin
    bad     = cmd_r && (dec == 3'd0 || dec > 3'd3);
    sh      = cmd_r ? dec[1:0] : 2'd0;
    bs      = bcd >> {sh, 2'b00};
    nd      = bs[23:0];
    interr  = |bs[39:24];
    intzero = !interr && (nd == 24'd0);
    unique case (sh)
      2'd1:    fr = {8'd0, bcd[3:0]};
      2'd2:    fr = {4'd0, bcd[7:0]};
      2'd3:    fr = bcd[11:0];
      default: fr = 12'd0;
    endcase
    frzero = (fr == 12'd0);
    if (fr[3:0] != 4'd0) fv = fr;
    else if (fr[7:4] != 4'd0) fv = fr >> 4;
    else fv = fr >> 8;
    if (fr[11:8] != 4'd0) top = 2'd2;
    else if (fr[7:4] != 4'd0) top = 2'd1;
    else top = 2'd0;
    lz = sh - 2'd1 - top;
    ki = slot - SLOT_INT;
    kf = slot - SLOT_FRAC;
  end

  always_comb begin
    cur = '0;
    if (slot == SLOT_MINUS) begin
      cur = {neg && !bad, W_MINUS};
    end else if (slot == SLOT_ERROR) begin
      cur = {bad || interr, W_ERROR};
    end else if (slot == SLOT_ZERO) begin
      cur = {!bad && intzero, W_ZERO};
    end else if (slot < SLOT_POINT) begin
      if (!bad && !interr && !intzero) cur = mag_slot(nd, ki[3:0]);
    end else if (slot == SLOT_POINT) begin
      cur = {cmd_r && !bad, W_POINT};
    end else if (slot == SLOT_LZ1) begin
      cur = {cmd_r && !bad && (frzero || lz >= 2'd1), W_ZERO};
    end else if (slot == SLOT_LZ2) begin
      cur = {cmd_r && !bad && !frzero && lz >= 2'd2, W_ZERO};
    end else if (slot <= SLOT_LAST) begin
      if (cmd_r && !bad && !frzero) cur = mag_slot({12'd0, fv}, kf[3:0]);
    end
  end

  assign stat.conv_done = (cnt == 5'd31);
  assign stat.slot_end  = (slot == SLOT_LAST);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= cmd;
      dec   <= decimals;
      neg   <= value[31];
      bin   <= value[31] ? 32'(-value) : 32'(value);
      bcd   <= '0;
      cnt   <= '0;
      slot  <= '0;
    end
    if (ctl.shift) begin
      bcd <= {bcd_adj[38:0], bin[31]};
      bin <= {bin[30:0], 1'b0};
      cnt <= cnt + 5'd1;
    end
    if (ctl.speak) begin
      slot <= slot + 5'd1;
      if (cur.valid) begin
        pword <= cur.word;
        word  <= pword;
        last  <= 1'b0;
      end
    end
    if (ctl.flush) begin
      word <= pword;
      last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= (ctl.speak && cur.valid && pvalid) || (ctl.flush && pvalid);
      if (ctl.load || ctl.flush) pvalid <= 1'b0;
      else if (ctl.speak && cur.valid) pvalid <= 1'b1;
    end
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the number-to-words block against an in-bench word predictor. A
// driver issues queued commands in random bursts, a monitor compares every
// strobed word and its last flag with the oldest predicted word.
// ----------------------------------------------------------------------------
module testbench
  import nwt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        cmd;
    logic [31:0] value;
    logic [2:0]  decimals;
  } number_req_t;

  typedef struct {
    logic [5:0] word;
    logic       last;
  } spoken_word_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               cmd;
  logic signed [31:0] value;
  logic [2:0]         decimals;
  logic               strobe;
  logic [5:0]         word;
  logic               last;

  number_req_t  pending_q[$];
  spoken_word_t words_due[$];
  logic [5:0]   wlist[$];
  int           failures = 0;
  int           cycles;
  int           gap_left;
  int           burst_left;
  bit           hold_off;
  bit           stim_done;

  number_to_word_tokens_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .value(value), .decimals(decimals), .strobe(strobe), .word(word),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void say_unit(int unsigned n);
    if (n >= 1 && n <= 19) wlist.push_back(6'(17 + n));
  endfunction

  function automatic void say_below_thousand(int unsigned n);
    int unsigned h;
    if (n >= 100) begin
      h = (n / 100) % 10;
      if (h == 1) wlist.push_back(W_HUNDRED);
      else if (h == 2) wlist.push_back(W_TWOHUNDRED);
      else if (h <= 4) begin
        say_unit(h);
        wlist.push_back(W_HUND_FEW);
      end else begin
        say_unit(h);
        wlist.push_back(W_HUND_MANY);
      end
      n = n % 100;
    end
    if (n >= 20) begin
      wlist.push_back(6'(8 + (n / 10) % 10));
      n = n % 10;
    end
    say_unit(n);
  endfunction

  function automatic void say_magnitude(longint unsigned m);
    int unsigned q;
    if (m >= 1000000) wlist.push_back(W_ERROR);
    else if (m == 1000) wlist.push_back(W_THOUSAND);
    else if (m > 1000) begin
      q = int'(m / 1000);
      say_below_thousand(q);
      wlist.push_back((q % 10 >= 2 && q % 10 <= 4) ? W_THOUSANDS : W_THOUSAND);
      say_below_thousand(int'(m % 1000));
    end else say_below_thousand(int'(m));
  endfunction

  function automatic void predict_words(number_req_t r);
    logic            neg;
    longint unsigned mag, scale, q, f, lim;
    spoken_word_t    sw;
    wlist.delete();
    neg = r.value[31];
    mag = neg ? (64'h1_0000_0000 - {32'd0, r.value}) : {32'd0, r.value};
    if (r.cmd == 1'b0) begin
      if (mag == 0) wlist.push_back(W_ZERO);
      else begin
        if (neg) wlist.push_back(W_MINUS);
        say_magnitude(mag);
      end
    end else if (r.decimals < 1 || r.decimals > 3) begin
      wlist.push_back(W_ERROR);
    end else begin
      scale = (r.decimals == 1) ? 10 : (r.decimals == 2) ? 100 : 1000;
      q = mag / scale;
      f = mag % scale;
      if (neg) wlist.push_back(W_MINUS);
      if (q == 0) wlist.push_back(W_ZERO);
      else say_magnitude(q);
      wlist.push_back(W_POINT);
      if (f == 0) wlist.push_back(W_ZERO);
      else begin
        lim = scale / 10;
        while (f < lim) begin
          wlist.push_back(W_ZERO);
          f = f * 10;
        end
        while (f % 10 == 0) f = f / 10;
        say_magnitude(f);
      end
    end
    foreach (wlist[i]) begin
      sw.word = wlist[i];
      sw.last = (i == wlist.size() - 1);
      words_due.push_back(sw);
    end
  endfunction

  function automatic number_req_t mk(logic c, logic [31:0] v, logic [2:0] d);
    number_req_t r;
    r.cmd = c;
    r.value = v;
    r.decimals = d;
    return r;
  endfunction

  function automatic logic [31:0] rand_value();
    int unsigned k;
    logic [31:0] v;
    k = $urandom_range(0, 9);
    if (k < 4) v = $urandom_range(0, 1999);
    else if (k < 8) v = $urandom_range(0, 999999);
    else if (k < 9) v = $urandom_range(999000, 1001000);
    else v = $urandom;
    if ($urandom_range(0, 2) == 0) v = -v;
    return v;
  endfunction

  initial begin
    number_req_t r;
    pending_q.push_back(mk(1'b0, 32'd0, 3'd0));
    pending_q.push_back(mk(1'b0, 32'd1000, 3'd5));
    pending_q.push_back(mk(1'b0, 32'd999999, 3'd0));
    pending_q.push_back(mk(1'b0, 32'd1000000, 3'd0));
    pending_q.push_back(mk(1'b0, 32'h7FFF_FFFF, 3'd7));
    pending_q.push_back(mk(1'b0, 32'h8000_0000, 3'd0));
    pending_q.push_back(mk(1'b0, 32'h8000_0001, 3'd0));
    pending_q.push_back(mk(1'b0, -32'd1, 3'd0));
    pending_q.push_back(mk(1'b0, 32'd234567, 3'd0));
    pending_q.push_back(mk(1'b0, 32'd112013, 3'd0));
    pending_q.push_back(mk(1'b0, 32'd2000, 3'd0));
    pending_q.push_back(mk(1'b0, 32'd5811, 3'd0));
    pending_q.push_back(mk(1'b1, -32'd1234, 3'd0));
    pending_q.push_back(mk(1'b1, 32'd1234, 3'd4));
    pending_q.push_back(mk(1'b1, 32'd1234, 3'd7));
    pending_q.push_back(mk(1'b1, 32'd5, 3'd1));
    pending_q.push_back(mk(1'b1, -32'd50, 3'd2));
    pending_q.push_back(mk(1'b1, 32'd1005, 3'd3));
    pending_q.push_back(mk(1'b1, 32'd100, 3'd3));
    pending_q.push_back(mk(1'b1, 32'd12340, 3'd3));
    pending_q.push_back(mk(1'b1, 32'd1000000000, 3'd3));
    pending_q.push_back(mk(1'b1, 32'h8000_0000, 3'd2));
    pending_q.push_back(mk(1'b1, 32'h7FFF_FFFF, 3'd1));
    pending_q.push_back(mk(1'b1, 32'd999999999, 3'd3));
    repeat (126) begin
      r.cmd = $urandom_range(0, 1);
      r.value = rand_value();
      r.decimals = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(1, 3));
      pending_q.push_back(r);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cmd <= 1'b0;
      value <= '0;
      decimals <= '0;
      gap_left <= 0;
      burst_left <= $urandom_range(1, 8);
      hold_off <= 1'b0;
      stim_done <= 1'b0;
    end else if (start && busy) begin
    end else begin
      if (start) begin
        predict_words(mk(cmd, value, decimals));
      end
      if (hold_off && words_due.size() != 0) begin
        start <= 1'b0;
      end else if (pending_q.size() == 0) begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else begin
        number_req_t r;
        r = pending_q.pop_front();
        hold_off <= (pending_q.size() == 70);
        start <= 1'b1;
        cmd <= r.cmd;
        value <= r.value;
        decimals <= r.decimals;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
        end else burst_left <= burst_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    spoken_word_t e;
    if (!rst && strobe) begin
      if (words_due.size() == 0) begin
        $display("%0t: unexpected word expected none actual word=%0d last=%0b",
                 $realtime, word, last);
        failures++;
      end else begin
        e = words_due.pop_front();
        if (word !== e.word) begin
          $display("%0t: word expected %0d actual %0d", $realtime, e.word, word);
          failures++;
        end
        if (last !== e.last) begin
          $display("%0t: last expected %0b actual %0b", $realtime, e.last, last);
          failures++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (!(stim_done && words_due.size() == 0 && !busy) && cycles < 200000) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= 200000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      repeat (80) @(posedge clk);
      if (failures == 0 && words_due.size() == 0) begin
        $display("SCOREBOARD CLEAN");
      end else begin
        $display("SCOREBOARD MISMATCH");
      end
      $finish;
    end
  end

endmodule
